>>> src/rrsl_pkg.sv
package rrsl_pkg;

   // list capacity and field widths
   localparam int MAX_CLIENTS = 16;
   localparam int ID_W        = 4;
   localparam int COUNT_W     = $clog2(MAX_CLIENTS + 1);

   // request opcodes (code 3 is unused and does nothing)
   typedef enum logic [1:0] {
      OP_BIND   = 2'd0,
      OP_NEXT   = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_EMPTY       = 2'd1,
      ST_NOT_BOUND   = 2'd2,
      ST_FULL_OR_DUP = 2'd3
   } status_type;

   // command broadcast from the control to every slot cell; the requested id
   // goes to the cells on its own so the match chain does not feed back into it
   typedef struct packed {
      logic            bind_en;
      logic            next_en;
      logic            remove_en;
      logic [ID_W-1:0] head_id;
   } cell_cmd_type;

endpackage

>>> src/rrsl_cell.sv
module rrsl_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  rrsl_pkg::cell_cmd_type    cmd,
   input  logic [rrsl_pkg::ID_W-1:0] client_id,
   input  logic                      prev_valid,
   input  logic [rrsl_pkg::ID_W-1:0] next_id,
   input  logic                      next_valid,
   input  logic                      hit_in,
   output logic [rrsl_pkg::ID_W-1:0] id_out,
   output logic                      valid_out,
   output logic                      hit_out
);

   logic [rrsl_pkg::ID_W-1:0] id_ff;
   logic [rrsl_pkg::ID_W-1:0] id_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      match;

   // compare against the requested id; hit travels toward the tail
   assign match   = valid_ff && (id_ff == client_id);
   assign hit_out = hit_in | match;

   // slot update for each command
   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      if (cmd.bind_en && !valid_ff && prev_valid) begin
         // first free slot takes the new id
         id_in    = client_id;
         valid_in = 1'b1;
      end else if (cmd.next_en && valid_ff) begin
         // rotate: shift toward head, tail takes the old head
         if (next_valid) begin
            id_in = next_id;
         end else begin
            id_in = cmd.head_id;
         end
      end else if (cmd.remove_en && hit_out) begin
         // close the gap at and after the removed slot
         id_in    = next_id;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out    = id_ff;
   assign valid_out = valid_ff;

endmodule

>>> src/round_robin_service_list_unit.sv
// A request accepted at a clock edge shows its result with rsp_strobe in the
// cycle that follows it.
// Throughput: one request per cycle while busy is low; each slot cell compares and shifts
// in the same cycle, with the match chain running through the row of cells.
// Reset (synchronous): clears the slot valid bits and the list length; busy is high
// while reset is held. The receiver cannot stall results.
module round_robin_service_list_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [rrsl_pkg::ID_W-1:0]    req_client_id,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [rrsl_pkg::ID_W-1:0]    rsp_served_id,
   output logic [rrsl_pkg::COUNT_W-1:0] rsp_bound_count
);

   localparam int N = rrsl_pkg::MAX_CLIENTS;

   logic [rrsl_pkg::ID_W-1:0]    cell_id    [N+1];
   logic                         cell_valid [N+1];
   logic                         cell_hit   [N+1];
   logic                         accept;
   logic                         full;
   logic                         empty;
   logic                         any_hit;
   rrsl_pkg::op_type             op;
   rrsl_pkg::cell_cmd_type       cmd;
   rrsl_pkg::status_type         status;
   logic [rrsl_pkg::ID_W-1:0]    served;
   logic [rrsl_pkg::COUNT_W-1:0] length_ff;
   logic [rrsl_pkg::COUNT_W-1:0] length_in;
   logic                         strobe_ff;
   logic [1:0]                   status_ff;
   logic [rrsl_pkg::ID_W-1:0]    served_ff;
   logic [rrsl_pkg::COUNT_W-1:0] count_ff;

   assign busy   = reset;
   assign accept = start && !busy;
   assign op     = rrsl_pkg::op_type'(req_opcode);
   assign full   = (length_ff == rrsl_pkg::COUNT_W'(N));
   assign empty  = (length_ff == '0);
   assign any_hit = cell_hit[N];

   // chain ends: head sees a valid left neighbor, tail a missing right neighbor
   assign cell_valid[N] = 1'b0;
   assign cell_id[N]    = '0;
   assign cell_hit[0]   = 1'b0;

   // row of slot cells, head at index 0
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                      hit_o;
      logic [rrsl_pkg::ID_W-1:0] id_o;
      logic                      valid_o;
      logic                      prev_v;

      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = cell_valid[i-1];
      end

      rrsl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .client_id  (req_client_id),
         .prev_valid (prev_v),
         .next_id    (cell_id[i+1]),
         .next_valid (cell_valid[i+1]),
         .hit_in     (cell_hit[i]),
         .id_out     (id_o),
         .valid_out  (valid_o),
         .hit_out    (hit_o)
      );

      assign cell_id[i]    = id_o;
      assign cell_valid[i] = valid_o;
      assign cell_hit[i+1] = hit_o;
   end

   // command decode, status and new length
   always_comb begin
      cmd           = '0;
      cmd.head_id   = cell_id[0];
      status        = rrsl_pkg::ST_OK;
      served        = '0;
      length_in     = length_ff;
      case (op)
         rrsl_pkg::OP_BIND: begin
            if (full || any_hit) begin
               status = rrsl_pkg::ST_FULL_OR_DUP;
            end else begin
               cmd.bind_en = accept;
               if (accept) begin
                  length_in = length_ff + rrsl_pkg::COUNT_W'(1);
               end
            end
         end
         rrsl_pkg::OP_NEXT: begin
            if (empty) begin
               status = rrsl_pkg::ST_EMPTY;
            end else begin
               cmd.next_en = accept;
               served      = cell_id[0];
            end
         end
         rrsl_pkg::OP_REMOVE: begin
            if (!any_hit) begin
               status = rrsl_pkg::ST_NOT_BOUND;
            end else begin
               cmd.remove_en = accept;
               if (accept) begin
                  length_in = length_ff - rrsl_pkg::COUNT_W'(1);
               end
            end
         end
         default: begin
            status = rrsl_pkg::ST_OK;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         strobe_ff <= accept;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
         served_ff <= served;
         count_ff  <= length_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_served_id   = served_ff;
   assign rsp_bound_count = count_ff;

endmodule

>>> src/rrsl_checker.sv
module rrsl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [1:0]                   rsp_status,
   input logic [rrsl_pkg::ID_W-1:0]    rsp_served_id,
   input logic [rrsl_pkg::COUNT_W-1:0] rsp_bound_count
);

   // every transfer in gives exactly one result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted request gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without a request");

   // failed operations never name a client
   a_err_served_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != rrsl_pkg::ST_OK) |-> (rsp_served_id == '0))
      else $error("error result carries a served id");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_bound_count <= rrsl_pkg::COUNT_W'(rrsl_pkg::MAX_CLIENTS)))
      else $error("bound count beyond capacity");

endmodule

bind round_robin_service_list_unit rrsl_checker u_rrsl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_served_id   (rsp_served_id),
   .rsp_bound_count (rsp_bound_count)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rrsl_pkg::*;

   // opcode 3 has no operation behind it
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 100;

   // one predicted response
   typedef struct {
      status_type          status;
      logic [ID_W-1:0]     served_id;
      logic [COUNT_W-1:0]  bound_count;
   } list_rsp_t;

   // scoreboard: tracks the service order and the responses still due
   class service_order_board;
      logic [ID_W-1:0] slots[MAX_CLIENTS];
      int              length;
      list_rsp_t       due_rsp[$];
      int              errors;

      function new();
         length = 0;
         errors = 0;
      endfunction

      // index of id in the order, or length when absent
      function int position_of(logic [ID_W-1:0] id);
         for (int i = 0; i < length; i++) begin
            if (slots[i] == id) return i;
         end
         return length;
      endfunction

      function int pending();
         return due_rsp.size();
      endfunction

      // a bound id whenever the list is not empty, else any id
      function logic [ID_W-1:0] pick_bound();
         if (length == 0) return ID_W'($urandom_range(0, 15));
         return slots[$urandom_range(0, length - 1)];
      endfunction

      // an id not yet bound, when one is found within a few draws
      function logic [ID_W-1:0] pick_unbound();
         logic [ID_W-1:0] id;
         id = ID_W'($urandom_range(0, 15));
         for (int n = 0; n < 16 && position_of(id) < length; n++) begin
            id = ID_W'($urandom_range(0, 15));
         end
         return id;
      endfunction

      // predict the response for one accepted request
      function void note_request(logic [1:0] op, logic [ID_W-1:0] id);
         list_rsp_t       rsp;
         int              pos;
         logic [ID_W-1:0] head;
         rsp.status = ST_OK;
         rsp.served_id = '0;
         pos = position_of(id);
         case (op)
            OP_BIND: begin
               if (length >= MAX_CLIENTS || pos < length) begin
                  rsp.status = ST_FULL_OR_DUP;
               end else begin
                  slots[length] = id;
                  length++;
               end
            end
            OP_NEXT: begin
               if (length == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  head = slots[0];
                  for (int i = 1; i < length; i++) slots[i-1] = slots[i];
                  slots[length-1] = head;
                  rsp.served_id = head;
               end
            end
            OP_REMOVE: begin
               if (pos >= length) begin
                  rsp.status = ST_NOT_BOUND;
               end else begin
                  for (int i = pos + 1; i < length; i++) slots[i-1] = slots[i];
                  length--;
               end
            end
            default: ;
         endcase
         rsp.bound_count = COUNT_W'(length);
         due_rsp.push_back(rsp);
      endfunction

      // compare one transfer on the response side with the oldest prediction
      function void check_response(logic [1:0] status, logic [ID_W-1:0] served,
                                   logic [COUNT_W-1:0] count);
         list_rsp_t rsp;
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected response status %0d served %0d count %0d",
                     $time, status, served, count);
            errors++;
            return;
         end
         rsp = due_rsp.pop_front();
         if (status !== rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, rsp.status, status);
            errors++;
         end
         if (served !== rsp.served_id) begin
            $display("%0t: served_id expected %0d actual %0d",
                     $time, rsp.served_id, served);
            errors++;
         end
         if (count !== rsp.bound_count) begin
            $display("%0t: bound_count expected %0d actual %0d",
                     $time, rsp.bound_count, count);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_opcode = OP_UNUSED;
   logic [ID_W-1:0]     req_client_id = '0;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [ID_W-1:0]     rsp_served_id;
   logic [COUNT_W-1:0]  rsp_bound_count;

   service_order_board board;
   int                 cycle_count = 0;

   round_robin_service_list_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_client_id   (req_client_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_served_id   (rsp_served_id),
      .rsp_bound_count (rsp_bound_count)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // monitor at the falling edge, where every signal is settled
   always @(negedge clock) begin
      if (!reset && board != null) begin
         if (rsp_strobe) board.check_response(rsp_status, rsp_served_id, rsp_bound_count);
         if (start && !busy) board.note_request(req_opcode, req_client_id);
      end
   end

   // one request transfer; called and returning right after a rising edge
   task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                               input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_client_id <= id;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // hold the request side until every predicted response has arrived
   task automatic drain_responses();
      start <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int              r;
      int              gap;
      int              bind_pct;
      int              remove_pct;
      bit              no_gaps;
      logic [1:0]      op;
      logic [ID_W-1:0] id;

      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list errors, unused opcode, duplicate, full, removal positions
      send_request(OP_NEXT, 4'd5, 0);
      send_request(OP_REMOVE, 4'd3, 1);
      send_request(OP_UNUSED, 4'd15, 0);
      send_request(OP_BIND, 4'd0, 2);
      send_request(OP_BIND, 4'd15, 0);
      send_request(OP_BIND, 4'd15, 0);
      send_request(OP_NEXT, 4'd0, 3);
      for (int i = 1; i <= 14; i++) send_request(OP_BIND, ID_W'(i), i % 3);
      send_request(OP_BIND, 4'd9, 0);
      send_request(OP_REMOVE, 4'd14, 0);
      send_request(OP_REMOVE, 4'd15, 1);
      send_request(OP_REMOVE, 4'd7, 0);
      send_request(OP_NEXT, 4'd10, 0);
      drain_responses();

      // random phases alternating between filling and draining the list
      no_gaps = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         bind_pct   = (p % 2 == 0) ? 55 : 25;
         remove_pct = (p % 2 == 0) ? 20 : 45;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            r = $urandom_range(0, 99);
            if (r < bind_pct) begin
               op = OP_BIND;
               id = ($urandom_range(0, 3) != 0) ? board.pick_unbound()
                                                : ID_W'($urandom_range(0, 15));
            end else if (r < bind_pct + remove_pct) begin
               op = OP_REMOVE;
               id = ($urandom_range(0, 3) != 0) ? board.pick_bound()
                                                : ID_W'($urandom_range(0, 15));
            end else if (r < 95) begin
               op = OP_NEXT;
               id = ID_W'($urandom_range(0, 15));
            end else begin
               op = OP_UNUSED;
               id = ID_W'($urandom_range(0, 15));
            end
            send_request(op, id, gap);
         end
         if (p % 2 == 1) drain_responses();
      end

      // let the last responses come back, then settle
      drain_responses();
      repeat (4) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/rrsl_pkg.sv
src/rrsl_cell.sv
src/round_robin_service_list_unit.sv
src/rrsl_checker.sv
test/testbench.sv
